/* hdl/fdeg_pkg.sv */
`timescale 1ns / 1ps

package fdeg_pkg;

  // Geometry defaults for the stored frame
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Configuration port
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_CHANGE_THRESHOLD
  } cfg_index_e;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 9'd256;
  localparam logic [7:0]            THRESHOLD_RST    = 8'd0;

  // Gray conversion: (R*4899 + G*9617 + B*1868 + 8192) >> 14
  localparam int GRAY_ACC_W = 22;
  localparam int GRAY_SHIFT = 14;
  localparam logic [GRAY_ACC_W-1:0] GRAY_R_COEF = 22'd4899;
  localparam logic [GRAY_ACC_W-1:0] GRAY_G_COEF = 22'd9617;
  localparam logic [GRAY_ACC_W-1:0] GRAY_B_COEF = 22'd1868;
  localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND  = 22'd8192;

  // Event queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CFG_DATA_W-1:0] frame_width;
    logic [CFG_DATA_W-1:0] frame_height;
    logic [7:0]            change_threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0] event_x;
    logic [7:0] event_y;
    logic       polarity;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } push_t;

  typedef struct packed {
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

endpackage

/* hdl/fdeg_pixel_if.sv */
`timescale 1ns / 1ps

interface fdeg_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hdl/fdeg_event_if.sv */
`timescale 1ns / 1ps

interface fdeg_event_if;
  logic       valid;
  logic       ready;
  logic [7:0] event_x;
  logic [7:0] event_y;
  logic       polarity;

  modport source (output valid, output event_x, output event_y, output polarity, input ready);
  modport sink   (input valid, input event_x, input event_y, input polarity, output ready);
endinterface

/* hdl/fdeg_ram.sv */
`timescale 1ns / 1ps

module fdeg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/fdeg_front.sv */
`timescale 1ns / 1ps

module fdeg_front #(
  parameter int MAX_WIDTH  = fdeg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fdeg_pkg::MAX_HEIGHT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  fdeg_pixel_if.sink              pix_i,
  input  fdeg_pkg::cfg_t          cfg_i,
  input  fdeg_pkg::queue_status_t status_i,
  output fdeg_pkg::push_t         push_o
);

  import fdeg_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
  localparam int SH    = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                         $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;

  // position and first-frame flag
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          pv_q, pv_d;

  logic          accept;
  logic [QUEUE_CNT_W:0] used;
  logic [SW-1:0] w_eff;
  logic [SH-1:0] h_eff;
  logic [AW-1:0] addr_new;

  // stage 1: products, address
  logic                  s1_v_q;
  logic [GRAY_ACC_W-1:0] s1_pr_q, s1_pg_q, s1_pb_q;
  logic [AW-1:0]         s1_addr_q;
  logic [CW-1:0]         s1_col_q;
  logic [RW-1:0]         s1_row_q;
  logic                  s1_pv_q;
  logic                  s1_fwd_q;

  logic [GRAY_ACC_W-1:0] sum;
  logic [7:0]            gray1;
  logic [7:0]            old1;
  logic [7:0]            ram_rdata;

  // stage 2: gray against old, classify
  logic          s2_v_q;
  logic [7:0]    s2_gray_q, s2_old_q;
  logic [CW-1:0] s2_col_q;
  logic [RW-1:0] s2_row_q;
  logic          s2_pv_q;
  logic          brighter, darker;

  // room in the queue for every item still in flight
  assign used = {1'b0, status_i.count} + (QUEUE_CNT_W+1)'(s1_v_q)
              + (QUEUE_CNT_W+1)'(s2_v_q);
  assign pix_i.ready = used < (QUEUE_CNT_W+1)'(QUEUE_DEPTH);
  assign accept = pix_i.valid && pix_i.ready;

  // zero acts as one, oversize as the maximum
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w_eff = SW'(1);
    end else if (SW'(cfg_i.frame_width) > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      h_eff = SH'(1);
    end else if (SH'(cfg_i.frame_height) > SH'(MAX_HEIGHT)) begin
      h_eff = SH'(MAX_HEIGHT);
    end else begin
      h_eff = SH'(cfg_i.frame_height);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pv_d  = pv_q;
    if (accept) begin
      if (SW'(col_q) + SW'(1) >= w_eff) begin
        col_d = '0;
        if (SH'(row_q) + SH'(1) >= h_eff) begin
          row_d = '0;
          pv_d  = 1'b1;
        end else begin
          row_d = RW'(row_q + RW'(1));
        end
      end else begin
        col_d = CW'(col_q + CW'(1));
      end
    end
  end

  assign addr_new = AW'(AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pv_q   <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pv_q   <= pv_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pr_q   <= GRAY_ACC_W'(pix_i.red) * GRAY_R_COEF;
      s1_pg_q   <= GRAY_ACC_W'(pix_i.green) * GRAY_G_COEF;
      s1_pb_q   <= GRAY_ACC_W'(pix_i.blue) * GRAY_B_COEF;
      s1_addr_q <= addr_new;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_pv_q   <= pv_q;
      // item ahead writes the same pixel on this edge: RAM returns stale data
      s1_fwd_q  <= s1_v_q && (s1_addr_q == addr_new);
    end
    if (s1_v_q) begin
      s2_gray_q <= gray1;
      s2_old_q  <= old1;
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
      s2_pv_q   <= s1_pv_q;
    end
  end

  assign sum   = s1_pr_q + s1_pg_q + s1_pb_q + GRAY_ROUND;
  assign gray1 = sum[GRAY_ACC_W-1:GRAY_SHIFT];
  assign old1  = s1_fwd_q ? s2_gray_q : ram_rdata;

  fdeg_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_addr_q),
    .wdata_i (gray1),
    .raddr_i (addr_new),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    brighter = (s2_gray_q > s2_old_q) &&
               (8'(s2_gray_q - s2_old_q) > cfg_i.change_threshold);
    darker   = (s2_old_q > s2_gray_q) &&
               (8'(s2_old_q - s2_gray_q) > cfg_i.change_threshold);
    push_o.valid       = s2_v_q && s2_pv_q && (brighter || darker);
    push_o.ev.event_x  = 8'(s2_col_q);
    push_o.ev.event_y  = 8'(s2_row_q);
    push_o.ev.polarity = !brighter;
  end

endmodule

/* hdl/fdeg_back.sv */
`timescale 1ns / 1ps

module fdeg_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fdeg_pkg::push_t         push_i,
  output fdeg_pkg::queue_status_t status_o,
  fdeg_event_if.source            evt_o
);

  import fdeg_pkg::*;

  event_t                 ev_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   pop;

  assign evt_o.valid    = count_q != '0;
  assign evt_o.event_x  = ev_q[rd_ptr_q].event_x;
  assign evt_o.event_y  = ev_q[rd_ptr_q].event_y;
  assign evt_o.polarity = ev_q[rd_ptr_q].polarity;
  assign pop            = evt_o.valid && evt_o.ready;
  assign status_o.count = count_q;

  // front guarantees room before it takes an item
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                 QUEUE_PTR_W'(wr_ptr_q + QUEUE_PTR_W'(1));
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                 QUEUE_PTR_W'(rd_ptr_q + QUEUE_PTR_W'(1));
    end
    if (push_i.valid && !pop) begin
      count_d = QUEUE_CNT_W'(count_q + QUEUE_CNT_W'(1));
    end else if (!push_i.valid && pop) begin
      count_d = QUEUE_CNT_W'(count_q - QUEUE_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      ev_q[wr_ptr_q] <= push_i.ev;
    end
  end

endmodule

/* hdl/frame_difference_event_generator.sv */
`timescale 1ns / 1ps
// Frame-difference event generator.
// pix_i takes RGB pixels in raster order, one item per clock when ready is high.
// Each pixel is turned to gray and compared with the same pixel of the stored
// previous frame; a change above change_threshold gives one event item on evt_o
// (column, row, polarity 0 brighter / 1 darker). Pixels without change give none.
// Configuration (frame_width, frame_height, change_threshold) is written through
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write it only while no pixel
// is in flight, and the block itself does not enforce this.
// Throughput: one pixel per cycle while pix_i.ready is high; the frame RAM has a
// single write port, written once for each accepted pixel.
// An event passes stage 1, stage 2 and the queue before it shows on evt_o.
// Stall: evt_o has a four-entry queue; pix_i.ready drops once the queue plus the
// two pipeline stages would overflow, so nothing is lost while the sink stalls.
// Reset: position counters return to the first pixel and the first frame after
// reset is stored only, with no events. The frame RAM is not cleared.

module frame_difference_event_generator #(
  parameter int MAX_WIDTH  = fdeg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fdeg_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fdeg_pixel_if.sink                       pix_i,
  fdeg_event_if.source                     evt_o,
  input  logic                             cfg_we_i,
  input  logic [fdeg_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [fdeg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import fdeg_pkg::*;

  cfg_t          cfg_q;
  push_t         push;
  queue_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width      <= FRAME_WIDTH_RST;
      cfg_q.frame_height     <= FRAME_HEIGHT_RST;
      cfg_q.change_threshold <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:      cfg_q.frame_width      <= cfg_data_i;
        CFG_FRAME_HEIGHT:     cfg_q.frame_height     <= cfg_data_i;
        CFG_CHANGE_THRESHOLD: cfg_q.change_threshold <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  fdeg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .cfg_i    (cfg_q),
    .status_i (status),
    .push_o   (push)
  );

  fdeg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .status_o (status),
    .evt_o    (evt_o)
  );

endmodule
